// ----- hw/rtl/obs_pkg.sv -----
// Shared types and constants for the observer blend switch.
// No dependencies; imported by obs_decide, observer_blend_switch and obs_checker.
package obs_pkg;

	localparam int SPEED_W = 24;
	localparam int ANGLE_W = 16;
	localparam int LIMIT_W = 23;
	localparam int MARGIN_W = 22;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 56;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIS_MARGIN = 2'd2;

	localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST = 23'd300;
	localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 23'd1500;
	localparam logic [MARGIN_W-1:0] DIS_MARGIN_RST = 22'd200;

	// a twentieth of a turn, rounded down
	localparam logic [ANGLE_W-1:0] ANGLE_TOL = 16'd3276;
	localparam logic [ANGLE_W-1:0] ANGLE_TOL_NEG = 16'd62260;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd150;
	localparam logic signed [COUNT_W:0] COUNT_HIGH = 9'sd100;
	localparam logic signed [COUNT_W:0] COUNT_LOW = 9'sd30;

	localparam logic SRC_HFI = 1'b0;
	localparam logic SRC_SMO = 1'b1;

	typedef struct packed {
		logic signed [SPEED_W-1:0] hfi_speed;
		logic signed [SPEED_W-1:0] smo_speed;
		logic signed [SPEED_W-1:0] ref_speed;
		logic [ANGLE_W-1:0] hfi_angle;
		logic [ANGLE_W-1:0] smo_angle;
	} obs_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] agree_count;
		logic source_sel;
		logic signed [SPEED_W-1:0] held_speed;
		logic [ANGLE_W-1:0] held_angle;
		logic inject_enable;
	} obs_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] low_limit;
		logic [LIMIT_W-1:0] high_limit;
		logic [MARGIN_W-1:0] dis_margin;
	} obs_cfg_t;

	// magnitude of a signed speed; the most negative value maps to 2^23
	function automatic logic [SPEED_W-1:0] speed_mag(input logic signed [SPEED_W-1:0] v);
		logic [SPEED_W-1:0] r;
		r = v[SPEED_W-1] ? SPEED_W'(-v) : SPEED_W'(v);
		return r;
	endfunction

endpackage

// ----- hw/rtl/obs_decide.sv -----
// Next-state logic of the observer switch: agreement count, source choice
// and injection enable for one item. Uses obs_pkg.
module obs_decide (
	input  obs_pkg::obs_item_t  item,
	input  obs_pkg::obs_state_t cur,
	input  obs_pkg::obs_cfg_t   cfg,
	output obs_pkg::obs_state_t nxt
);
	import obs_pkg::*;

	logic [SPEED_W-1:0] habs, sabs, rabs, lo, hi;
	logic [ANGLE_W-1:0] diff;
	logic angle_ok, dir_ok, h_low, s_low, r_low, band;
	logic signed [COUNT_W:0] cnt;
	logic [SPEED_W+1:0] sabs_dbl, off_lim;
	logic [SPEED_W:0] on_lim;

	always_comb begin
		habs = speed_mag(item.hfi_speed);
		sabs = speed_mag(item.smo_speed);
		rabs = speed_mag(item.ref_speed);
		lo = SPEED_W'(cfg.low_limit);
		hi = SPEED_W'(cfg.high_limit);
		h_low = habs <= lo;
		s_low = sabs <= lo;
		r_low = rabs <= lo;

		// wrapped difference within the tolerance on either side
		diff = item.hfi_angle - item.smo_angle;
		angle_ok = (diff <= ANGLE_TOL) || (diff >= ANGLE_TOL_NEG);
		dir_ok = (!item.hfi_speed[SPEED_W-1] && !item.smo_speed[SPEED_W-1]) ||
			((item.hfi_speed[SPEED_W-1] || item.hfi_speed == '0) &&
			 (item.smo_speed[SPEED_W-1] || item.smo_speed == '0)) ||
			h_low || s_low;
		cnt = (angle_ok && dir_ok) ?
			$signed({1'b0, cur.agree_count}) + 9'sd1 :
			$signed({1'b0, cur.agree_count}) - 9'sd1;

		band = (rabs > lo && rabs < hi) ||
			(habs > lo && habs < hi && sabs > lo && sabs < hi);

		sabs_dbl = {1'b0, sabs, 1'b0};
		off_lim = (SPEED_W+2)'({cfg.high_limit, 1'b0}) +
			(SPEED_W+2)'({cfg.dis_margin, 1'b0}) + (SPEED_W+2)'(cfg.dis_margin);
		on_lim = (SPEED_W+1)'(cfg.high_limit) + (SPEED_W+1)'(cfg.dis_margin);

		nxt = cur;
		if (h_low || s_low || r_low) begin
			nxt.inject_enable = 1'b1;
			nxt.held_speed = item.hfi_speed;
			nxt.held_angle = item.hfi_angle;
			nxt.source_sel = SRC_HFI;
		end else if (band) begin
			// toggle on high confidence, refresh current source on low, else hold
			if (cnt >= COUNT_HIGH || cnt <= COUNT_LOW) begin
				if ((cnt >= COUNT_HIGH) ? (cur.source_sel == SRC_HFI) :
						(cur.source_sel == SRC_SMO)) begin
					nxt.held_speed = item.smo_speed;
					nxt.held_angle = item.smo_angle;
					nxt.source_sel = SRC_SMO;
				end else begin
					nxt.held_speed = item.hfi_speed;
					nxt.held_angle = item.hfi_angle;
					nxt.source_sel = SRC_HFI;
				end
			end
		end else begin
			if (sabs_dbl > off_lim)
				nxt.inject_enable = 1'b0;
			else if ((SPEED_W+1)'(sabs) < on_lim)
				nxt.inject_enable = 1'b1;
			nxt.held_speed = item.smo_speed;
			nxt.held_angle = item.smo_angle;
			nxt.source_sel = SRC_SMO;
		end

		if (cnt > $signed({1'b0, COUNT_MAX}))
			nxt.agree_count = COUNT_MAX;
		else if (cnt < 9'sd0)
			nxt.agree_count = '0;
		else
			nxt.agree_count = cnt[COUNT_W-1:0];
	end

endmodule

// ----- hw/rtl/observer_blend_switch.sv -----
// Top level of the observer blend switch: input register, state, result register.
// Depends on obs_pkg and obs_decide.
//
// One request on the s_ channel carries the speeds and angles of both rotor
// observers and the speed reference for one control period. One result
// follows on the m_ channel for every request: the chosen speed and angle,
// the chosen observer (m_tuser), the injection enable and the agreement count.
// A request is taken into an input register, and the decision logic then
// updates the state and loads the result register from it. Throughput is
// one request per cycle while results are taken, set by the single decision
// pass from input register to result register.
// When m_tready is low the result holds and one more request still enters
// the input register; after that s_tready drops until the result is taken.
// Reset empties both registers, clears the counter and held values, selects the
// injection observer with injection enabled, and loads the default limits
// (300, 1500, 200 rpm). Write cfg_* only while no request is in flight.
module observer_blend_switch (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// hfi_speed, smo_speed, ref_speed, hfi_angle, smo_angle
	input  logic [obs_pkg::IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// chosen_speed, chosen_angle, injection_on, confidence, zero pad
	output logic [obs_pkg::OUT_DATA_W-1:0] m_tdata,
	// chosen_source
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [obs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [obs_pkg::LIMIT_W-1:0] cfg_data
);
	import obs_pkg::*;

	obs_item_t item_s1;
	logic valid_s1;
	obs_state_t state_q, state_nxt, res_q;
	obs_cfg_t cfg_q;
	logic out_valid_q, advance;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit <= LOW_LIMIT_RST;
			cfg_q.high_limit <= HIGH_LIMIT_RST;
			cfg_q.dis_margin <= DIS_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_LIMIT: cfg_q.low_limit <= cfg_data;
				REG_HIGH_LIMIT: cfg_q.high_limit <= cfg_data;
				REG_DIS_MARGIN: cfg_q.dis_margin <= cfg_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.hfi_speed <= s_tdata[23:0];
			item_s1.smo_speed <= s_tdata[47:24];
			item_s1.ref_speed <= s_tdata[71:48];
			item_s1.hfi_angle <= s_tdata[87:72];
			item_s1.smo_angle <= s_tdata[103:88];
		end
	end

	obs_decide u_decide (
		.item(item_s1),
		.cur(state_q),
		.cfg(cfg_q),
		.nxt(state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.agree_count <= '0;
			state_q.source_sel <= SRC_HFI;
			state_q.held_speed <= '0;
			state_q.held_angle <= '0;
			state_q.inject_enable <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= state_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = res_q.source_sel;
	assign m_tdata = {7'd0, res_q.agree_count, res_q.inject_enable,
		res_q.held_angle, res_q.held_speed};

endmodule

// ----- hw/rtl/obs_checker.sv -----
// Port-level checks for observer_blend_switch, attached by bind.
// Depends on obs_pkg.
module obs_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [obs_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic m_tuser
);
	import obs_pkg::*;

	logic [COUNT_W-1:0] conf, prev_conf_q;
	logic seen_q;

	assign conf = m_tdata[48:41];

	// remember the count of the last result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			prev_conf_q <= '0;
		end else if (m_tvalid && m_tready) begin
			seen_q <= 1'b1;
			prev_conf_q <= conf;
		end
	end

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> conf <= COUNT_MAX)
		else $error("confidence above its clamp");

	a_conf_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && seen_q) |->
		((9'(conf) <= 9'(prev_conf_q) + 9'd1) && (9'(conf) + 9'd1 >= 9'(prev_conf_q))))
		else $error("confidence moved by more than one between results");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused while result register empty");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind observer_blend_switch obs_checker u_obs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
